>>> design/band_matrix_scatter_accumulate_top_assert.svh
// Assertion macros shared by the checker of the band matrix scatter accumulate block.
// The macros expect a signal named clk, and BMSA_ASSERT also rst_n, in the scope where they are used.
`ifndef BAND_MATRIX_SCATTER_ACCUMULATE_TOP_ASSERT_SVH
`define BAND_MATRIX_SCATTER_ACCUMULATE_TOP_ASSERT_SVH

// Checked on every rising edge outside reset.
`define BMSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BMSA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/bmsa_pkg.sv
// Package of the band matrix scatter accumulate block: sizes, field widths, codes and
// the command and status structs between controller and datapath. No dependencies.
package bmsa_pkg;

  localparam int MAX_EQN     = 256;
  localparam int MAX_STRIDE  = 32;
  localparam int STORE_DEPTH = MAX_EQN * MAX_STRIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int EQN_W       = $clog2(MAX_EQN);

  localparam int REQ_W  = 2;
  localparam int IDX_W  = 10;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int NEQ_W  = 9;
  localparam int DIAG_W = 4;
  localparam int LD_W   = 6;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int SUM_W  = PROD_W - FRAC_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = VAL_W;

  localparam logic [REQ_W-1:0] REQ_STIFF = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MASS  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_APPLIED   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DROPPED   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SATURATED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_IGNORED   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_EQN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUB     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPER   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT   = 2'd3;

  localparam logic signed [VAL_W-1:0] Q_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] Q_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic load;
    logic look;
    logic sweep;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_clear;
    logic sweep_done;
  } dp_sts_t;

endpackage

>>> design/bmsa_in_if.sv
// Input channel of the band matrix scatter accumulate block: valid, ready and one term.
// Depends on bmsa_pkg.
interface bmsa_in_if;
  import bmsa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [IDX_W-1:0] row_index;
  logic signed [IDX_W-1:0] col_index;
  logic signed [VAL_W-1:0] term_value;
  logic signed [VAL_W-1:0] term_scale;

  modport source (
    output valid, req_type, row_index, col_index, term_value, term_scale,
    input  ready
  );
  modport sink (
    input  valid, req_type, row_index, col_index, term_value, term_scale,
    output ready
  );
endinterface

>>> design/bmsa_out_if.sv
// Result channel of the band matrix scatter accumulate block: valid, ready, status, value.
// Depends on bmsa_pkg.
interface bmsa_out_if;
  import bmsa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] read_value;

  modport source (
    output valid, status, read_value,
    input  ready
  );
  modport sink (
    input  valid, status, read_value,
    output ready
  );
endinterface

>>> design/bmsa_ctrl.sv
// Controller of the band matrix scatter accumulate block: sequences the clearing pass,
// lookup, finish and output handshake. Depends on bmsa_pkg.
module bmsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bmsa_pkg::dp_cmd_t cmd,
  input  bmsa_pkg::dp_sts_t sts
);
  import bmsa_pkg::*;

  typedef enum logic [4:0] {
    ST_INIT  = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LOOK  = 5'b00100,
    ST_CLEAR = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   load;

  always_comb begin
    slot_free  = !out_valid_r || out_ready;
    in_ready   = (state_r == ST_IDLE) || ((state_r == ST_FIN) && slot_free);
    load       = in_valid && in_ready;
    cmd.load   = load;
    cmd.look   = (state_r == ST_LOOK);
    cmd.sweep  = ((state_r == ST_INIT) || (state_r == ST_CLEAR)) && !sts.sweep_done;
    cmd.commit = (state_r == ST_FIN) && slot_free;

    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (sts.sweep_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (load) state_nxt = sts.in_clear ? ST_CLEAR : ST_LOOK;
      end
      ST_LOOK: begin
        state_nxt = ST_FIN;
      end
      ST_CLEAR: begin
        if (sts.sweep_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          if (load) state_nxt = sts.in_clear ? ST_CLEAR : ST_LOOK;
          else      state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase

    if (cmd.commit)     out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> design/bmsa_datapath.sv
// Datapath of the band matrix scatter accumulate block: configuration registers, band
// address logic, Q16.16 multiply-accumulate with saturation and the band memory.
// Depends on bmsa_pkg.
module bmsa_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bmsa_pkg::dp_cmd_t                 cmd,
  output bmsa_pkg::dp_sts_t                 sts,
  input  logic [bmsa_pkg::REQ_W-1:0]        in_req_type,
  input  logic signed [bmsa_pkg::IDX_W-1:0] in_row_index,
  input  logic signed [bmsa_pkg::IDX_W-1:0] in_col_index,
  input  logic signed [bmsa_pkg::VAL_W-1:0] in_term_value,
  input  logic signed [bmsa_pkg::VAL_W-1:0] in_term_scale,
  input  logic                              cfg_wr_en,
  input  logic [bmsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bmsa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic [bmsa_pkg::STAT_W-1:0]       out_status,
  output logic signed [bmsa_pkg::VAL_W-1:0] out_read_value
);
  import bmsa_pkg::*;

  localparam int AF_W = EQN_W + LD_W + 1;
  localparam int NL_W = NEQ_W + LD_W;
  localparam logic [NEQ_W:0] MAX_EQN_V = (NEQ_W+1)'(MAX_EQN);

  logic [NEQ_W-1:0]        num_eq_r;
  logic [DIAG_W-1:0]       sub_r;
  logic [DIAG_W-1:0]       super_r;
  logic signed [VAL_W-1:0] shift_r;

  logic [REQ_W-1:0]        req_r;
  logic signed [IDX_W-1:0] row_r;
  logic signed [IDX_W-1:0] col_r;
  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] scale_r;

  logic [ADDR_W-1:0] addr_r;
  logic              ok_r;
  logic              zero_r;
  logic [PROD_W-1:0] prod_r;
  logic [VAL_W-1:0]  rdata_r;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] limit_r;

  logic [STAT_W-1:0]       status_r;
  logic signed [VAL_W-1:0] rdval_r;

  logic [VAL_W-1:0] band_mem [STORE_DEPTH];

  logic [LD_W-1:0]         ld;
  logic [LD_W-1:0]         in_ld;
  logic [NL_W-1:0]         clear_n;
  logic [CNT_W-1:0]        clear_lim;
  logic [NEQ_W-1:0]        row_u;
  logic [NEQ_W-1:0]        col_u;
  logic [EQN_W-1:0]        row_e;
  logic [EQN_W-1:0]        col_e;
  logic                    idx_ok;
  logic                    band_ok;
  logic                    loc_ok;
  logic [AF_W-1:0]         addr_full;
  logic [ADDR_W-1:0]       loc_addr;
  logic signed [VAL_W-1:0] scale_sel;
  logic signed [PROD_W-1:0] prod_full;
  logic [SUM_W-1:0]        sum;
  logic                    sat_hi;
  logic                    sat_lo;
  logic [VAL_W-1:0]        sat_val;
  logic [STAT_W-1:0]       fin_status;
  logic [VAL_W-1:0]        fin_rdval;
  logic                    add_we;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [VAL_W-1:0]        mem_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_eq_r <= '0;
      sub_r    <= '0;
      super_r  <= '0;
      shift_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_NUM_EQN: num_eq_r <= cfg_wdata[NEQ_W-1:0];
        CFG_SUB:     sub_r    <= cfg_wdata[DIAG_W-1:0];
        CFG_SUPER:   super_r  <= cfg_wdata[DIAG_W-1:0];
        CFG_SHIFT:   shift_r  <= $signed(cfg_wdata[VAL_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    ld        = LD_W'({sub_r, 1'b0}) + LD_W'(super_r) + LD_W'(1);
    in_ld     = ld;
    clear_n   = NL_W'(num_eq_r) * NL_W'(in_ld);
    clear_lim = (clear_n > NL_W'(STORE_DEPTH)) ? CNT_W'(STORE_DEPTH) : clear_n[CNT_W-1:0];

    row_u  = row_r[NEQ_W-1:0];
    col_u  = col_r[NEQ_W-1:0];
    row_e  = row_u[EQN_W-1:0];
    col_e  = col_u[EQN_W-1:0];
    idx_ok = !row_r[IDX_W-1] && !col_r[IDX_W-1] &&
             (row_u < num_eq_r) && (col_u < num_eq_r) &&
             ({1'b0, row_u} < MAX_EQN_V) && ({1'b0, col_u} < MAX_EQN_V);
    if (col_e > row_e) band_ok = (col_e - row_e) <= EQN_W'(super_r);
    else               band_ok = (row_e - col_e) <= EQN_W'(sub_r);
    loc_ok    = idx_ok && band_ok && (ld <= LD_W'(MAX_STRIDE));
    addr_full = AF_W'(col_e) * AF_W'(ld) + AF_W'(sub_r) + AF_W'(super_r) +
                AF_W'(row_e) - AF_W'(col_e);
    loc_addr  = addr_full[ADDR_W-1:0];

    if (req_r == REQ_MASS) scale_sel = (shift_r == Q_MIN) ? Q_MAX : -shift_r;
    else                   scale_sel = scale_r;
    prod_full = val_r * scale_sel;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req_type;
      row_r   <= in_row_index;
      col_r   <= in_col_index;
      val_r   <= in_term_value;
      scale_r <= in_term_scale;
    end
    if (cmd.look) begin
      addr_r <= loc_addr;
      ok_r   <= loc_ok;
      zero_r <= (scale_sel == '0);
      prod_r <= prod_full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      limit_r <= CNT_W'(STORE_DEPTH);
    end else if (cmd.load && (in_req_type == REQ_CLEAR)) begin
      cnt_r   <= '0;
      limit_r <= clear_lim;
    end else if (cmd.sweep) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    sum = SUM_W'($signed(rdata_r)) + SUM_W'($signed(prod_r[PROD_W-1:FRAC_W])) +
          SUM_W'(prod_r[FRAC_W-1]);
    sat_hi = !sum[SUM_W-1] && (sum[SUM_W-2:VAL_W-1] != '0);
    sat_lo = sum[SUM_W-1] && !(&sum[SUM_W-2:VAL_W-1]);
    if (sat_hi)      sat_val = Q_MAX;
    else if (sat_lo) sat_val = Q_MIN;
    else             sat_val = sum[VAL_W-1:0];

    fin_rdval = '0;
    add_we    = 1'b0;
    case (req_r)
      REQ_CLEAR: begin
        fin_status = STAT_APPLIED;
      end
      REQ_READ: begin
        if (ok_r) begin
          fin_status = STAT_APPLIED;
          fin_rdval  = rdata_r;
        end else begin
          fin_status = STAT_DROPPED;
        end
      end
      REQ_STIFF, REQ_MASS: begin
        if (zero_r) begin
          fin_status = STAT_IGNORED;
        end else if (!ok_r) begin
          fin_status = STAT_DROPPED;
        end else begin
          fin_status = (sat_hi || sat_lo) ? STAT_SATURATED : STAT_APPLIED;
          add_we     = 1'b1;
        end
      end
      default: begin
        fin_status = STAT_DROPPED;
      end
    endcase

    mem_we    = cmd.sweep || (cmd.commit && add_we);
    mem_waddr = cmd.sweep ? cnt_r[ADDR_W-1:0] : addr_r;
    mem_wdata = cmd.sweep ? '0 : sat_val;
  end

  always_ff @(posedge clk) begin
    if (mem_we) band_mem[mem_waddr] <= mem_wdata;
    rdata_r <= band_mem[loc_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= fin_status;
      rdval_r  <= $signed(fin_rdval);
    end
  end

  assign sts.in_clear   = (in_req_type == REQ_CLEAR);
  assign sts.sweep_done = (cnt_r == limit_r);
  assign out_status     = status_r;
  assign out_read_value = rdval_r;

endmodule

>>> design/band_matrix_scatter_accumulate_top.sv
// Top level of the band matrix scatter accumulate block: joins controller and datapath.
// Depends on bmsa_pkg, bmsa_in_if, bmsa_out_if, bmsa_ctrl and bmsa_datapath.
//
//   channel   direction  transfer moves
//   in_ch     sink       one request: type, row, column, value, scale
//   out_ch    source     one result: status, read value
//   cfg_*     input      one register write, no wait, no read-back
//
// An add or read goes through accept, lookup (band memory read and 32x32 multiply) and
// finish (saturating add and write-back); another request may be accepted during finish.
// A clear zeroes the lowest min(num_equations * stride, 8192) words of the band memory,
// one word cleared per cycle.
// After reset a clearing pass of 8192 words holds in_ch.ready low; config writes go on.
// A finished result waits in the output register; one more request may advance behind it.
module band_matrix_scatter_accumulate_top (
  input  logic                            clk,
  input  logic                            rst_n,
  bmsa_in_if.sink                         in_ch,
  bmsa_out_if.source                      out_ch,
  input  logic                            cfg_wr_en,
  input  logic [bmsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmsa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bmsa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bmsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bmsa_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (in_ch.req_type),
    .in_row_index   (in_ch.row_index),
    .in_col_index   (in_ch.col_index),
    .in_term_value  (in_ch.term_value),
    .in_term_scale  (in_ch.term_scale),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_status     (out_ch.status),
    .out_read_value (out_ch.read_value)
  );

endmodule

>>> design/bmsa_checker.sv
// Port-level checker of the band matrix scatter accumulate block and its bind statement.
// Depends on bmsa_pkg and band_matrix_scatter_accumulate_top_assert.svh.
`include "band_matrix_scatter_accumulate_top_assert.svh"

module bmsa_port_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [bmsa_pkg::STAT_W-1:0]      out_status,
  input logic signed [bmsa_pkg::VAL_W-1:0] out_read_value
);
  import bmsa_pkg::*;

  logic fail_shown;

  assign fail_shown = out_valid && (out_status != STAT_APPLIED);

  `BMSA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `BMSA_ASSERT_ALWAYS(a_reset_busy, !rst_n |=> !in_ready, "ready during clearing pass")
  `BMSA_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "request taken early")
  `BMSA_ASSERT(a_zero_unless_ok, fail_shown |-> out_read_value == 0, "value with failure status")

endmodule

bind band_matrix_scatter_accumulate_top bmsa_port_checker u_bmsa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_read_value (out_ch.read_value)
);
